### rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define CBA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/cba_pkg.sv
`default_nettype none
package cba_pkg;

    localparam int SIZE_BITS      = 40;
    localparam int ADDR_BITS      = 48;
    localparam int STAMP_BITS     = 16;
    localparam int COUNT_BITS     = 32;
    localparam int ABYTE_BITS     = 48;
    localparam int FREE_ENTRIES   = 64;
    localparam int ACTIVE_ENTRIES = 256;

    localparam logic [SIZE_BITS-1:0] LIMIT_RESET = 40'd1073741824;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RECORD  = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic [2:0] STAT_HIT      = 3'd0;
    localparam logic [2:0] STAT_MISS     = 3'd1;
    localparam logic [2:0] STAT_RECORDED = 3'd2;
    localparam logic [2:0] STAT_NOT_REC  = 3'd3;
    localparam logic [2:0] STAT_CACHED   = 3'd4;
    localparam logic [2:0] STAT_FREED    = 3'd5;

    typedef struct packed {
        logic [1:0]           action;
        logic [SIZE_BITS-1:0] request_size;
        logic [ADDR_BITS-1:0] block_address;
    } t_item;

    typedef struct packed {
        logic [2:0]            status;
        logic [ADDR_BITS-1:0]  result_address;
        logic [SIZE_BITS-1:0]  result_size;
        logic [COUNT_BITS-1:0] hit_count;
        logic [COUNT_BITS-1:0] miss_count;
        logic [6:0]            cached_block_count;
        logic [SIZE_BITS-1:0]  cached_byte_total;
        logic [8:0]            active_block_count;
        logic [ABYTE_BITS-1:0] active_byte_total;
    } t_result;

    typedef struct packed {
        logic [SIZE_BITS-1:0]  size;
        logic [ADDR_BITS-1:0]  addr;
        logic [STAMP_BITS-1:0] stamp;
    } t_free_word;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] size;
    } t_active_word;

endpackage
`default_nettype wire

### rtl/cba_ram.sv
`default_nettype none
module cba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/caching_block_allocator.sv
// Each word runs a sequence of table scans before o_done rises: allocate scans the free table and,
// on a hit, the active table too; record scans the active table; release scans the active table
// and, for a known block, the free table; an unused action goes straight to done.
// One word at a time: busy falls as o_done rises, and a new word is taken only while busy is low.
// The scans read one entry a cycle; results cannot be stalled.
// Reset is synchronous and active low; it clears valid bits and counters and reloads the limit.
`default_nettype none
`include "assert_macros.svh"
module caching_block_allocator #(
    parameter int FREE_ENTRIES   = cba_pkg::FREE_ENTRIES,
    parameter int ACTIVE_ENTRIES = cba_pkg::ACTIVE_ENTRIES
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    input  wire cba_pkg::t_item                 i_item,
    output logic                                busy,
    output logic                                o_done,
    output cba_pkg::t_result                    o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [cba_pkg::SIZE_BITS-1:0]  i_cfg_wdata
);

    localparam int SB  = cba_pkg::SIZE_BITS;
    localparam int AB  = cba_pkg::ADDR_BITS;
    localparam int BB  = cba_pkg::ABYTE_BITS;
    localparam int CB  = cba_pkg::COUNT_BITS;
    localparam int FIW = $clog2(FREE_ENTRIES);
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int AIW = $clog2(ACTIVE_ENTRIES);
    localparam int ACW = $clog2(ACTIVE_ENTRIES + 1);
    localparam int FWW = $bits(cba_pkg::t_free_word);
    localparam int AWW = $bits(cba_pkg::t_active_word);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FREE_SCAN = 4'd1;
    localparam logic [3:0] S_ALLOC_DEC = 4'd2;
    localparam logic [3:0] S_ACT_SCAN  = 4'd3;
    localparam logic [3:0] S_ACT_UPD   = 4'd4;
    localparam logic [3:0] S_ACT_ADD   = 4'd5;
    localparam logic [3:0] S_REL_SCAN  = 4'd6;
    localparam logic [3:0] S_REL_DEC   = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Configuration and statistics.
    logic [SB-1:0]  r_limit;
    logic [SB-1:0]  r_cached;
    logic [BB-1:0]  r_abytes;
    logic [CB-1:0]  r_hits;
    logic [CB-1:0]  r_misses;
    logic [FCW-1:0] r_fcnt;
    logic [ACW-1:0] r_acnt;
    logic [cba_pkg::STAMP_BITS-1:0] r_seq;

    logic [FREE_ENTRIES-1:0]   r_fvalid;
    logic [ACTIVE_ENTRIES-1:0] r_avalid;

    // The word being worked on.
    logic [1:0]    r_act;
    logic [SB-1:0] r_req;
    logic [AB-1:0] r_taddr;
    logic [SB-1:0] r_tsize;
    logic          r_from_hit;

    // Scan counters; the previous index names the entry whose read data is now valid.
    logic [FCW-1:0] r_fidx;
    logic [FIW-1:0] r_fpidx;
    logic [ACW-1:0] r_aidx;
    logic [AIW-1:0] r_apidx;

    // Best fit found so far in the free table.
    logic                           r_best_ok;
    logic [FIW-1:0]                 r_best_idx;
    logic [SB-1:0]                  r_best_size;
    logic [AB-1:0]                  r_best_addr;
    logic [cba_pkg::STAMP_BITS-1:0] r_best_age;

    // Active table lookup results.
    logic           r_a_found;
    logic [AIW-1:0] r_a_idx;
    logic [SB-1:0]  r_a_old;
    logic           r_a_slot_ok;
    logic [AIW-1:0] r_a_slot;

    // First empty free slot for a release.
    logic           r_f_slot_ok;
    logic [FIW-1:0] r_f_slot;

    // Result being assembled.
    logic [2:0]    r_status;
    logic [AB-1:0] r_raddr;
    logic [SB-1:0] r_rsize;

    cba_pkg::t_free_word   free_rd;
    cba_pkg::t_free_word   free_wd;
    cba_pkg::t_active_word act_rd;
    cba_pkg::t_active_word act_wd;
    logic [FWW-1:0]        free_rdata;
    logic [AWW-1:0]        act_rdata;
    logic                  free_we;
    logic                  act_we;
    logic [AIW-1:0]        act_waddr;

    logic [cba_pkg::STAMP_BITS-1:0] scan_age;
    logic                           scan_cand;
    logic                           scan_better;
    logic                           act_match;
    logic                           fits_twice;
    logic                           fits_limit;
    logic [BB:0]                    abytes_sum;
    logic [BB-1:0]                  abytes_sub;

    assign free_rd = cba_pkg::t_free_word'(free_rdata);
    assign act_rd  = cba_pkg::t_active_word'(act_rdata);

    assign free_wd.size  = r_a_old;
    assign free_wd.addr  = r_taddr;
    assign free_wd.stamp = r_seq;
    assign act_wd.addr   = r_taddr;
    assign act_wd.size   = r_tsize;

    assign free_we   = (r_state == S_REL_DEC) && fits_limit;
    assign act_we    = (r_state == S_ACT_UPD) && (r_act != cba_pkg::ACT_RELEASE)
                       && (r_a_found || r_a_slot_ok);
    assign act_waddr = r_a_found ? r_a_idx : r_a_slot;

    cba_ram #(.WIDTH(FWW), .DEPTH(FREE_ENTRIES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (r_f_slot),
        .i_wdata (free_wd),
        .i_raddr (r_fidx[FIW-1:0]),
        .o_rdata (free_rdata)
    );

    cba_ram #(.WIDTH(AWW), .DEPTH(ACTIVE_ENTRIES)) u_active_ram (
        .i_clk   (i_clk),
        .i_we    (act_we),
        .i_waddr (act_waddr),
        .i_wdata (act_wd),
        .i_raddr (r_aidx[AIW-1:0]),
        .o_rdata (act_rdata)
    );

    // Best-fit compare: a candidate is large enough, and beats the best so far when it is
    // smaller, or of equal size and older. A strictly greater age is needed, so equal ages
    // keep the lower slot that was seen first.
    assign scan_age    = r_seq - free_rd.stamp;
    assign scan_cand   = r_fvalid[r_fpidx] && (free_rd.size >= r_req);
    assign scan_better = !r_best_ok || (free_rd.size < r_best_size)
                         || ((free_rd.size == r_best_size) && (scan_age > r_best_age));
    assign act_match   = r_avalid[r_apidx] && (act_rd.addr == r_taddr);
    assign fits_twice  = {1'b0, r_best_size} <= {r_req, 1'b0};
    assign fits_limit  = r_f_slot_ok
                         && (({1'b0, r_cached} + {1'b0, r_a_old}) <= {1'b0, r_limit});
    assign abytes_sum  = {1'b0, r_abytes} + {{(BB + 1 - SB){1'b0}}, r_tsize};
    assign abytes_sub  = ({{(BB - SB){1'b0}}, r_a_old} > r_abytes) ? '0
                         : r_abytes - {{(BB - SB){1'b0}}, r_a_old};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.action)
                        cba_pkg::ACT_ALLOC:   n_state = S_FREE_SCAN;
                        cba_pkg::ACT_RECORD:  n_state = S_ACT_SCAN;
                        cba_pkg::ACT_RELEASE: n_state = S_ACT_SCAN;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_FREE_SCAN: begin
                if (r_fidx == FCW'(FREE_ENTRIES)) begin
                    n_state = S_ALLOC_DEC;
                end
            end
            S_ALLOC_DEC: n_state = (r_best_ok && fits_twice) ? S_ACT_SCAN : S_DONE;
            S_ACT_SCAN: begin
                if (r_aidx == ACW'(ACTIVE_ENTRIES)) begin
                    n_state = S_ACT_UPD;
                end
            end
            S_ACT_UPD: begin
                if (r_act == cba_pkg::ACT_RELEASE) begin
                    n_state = r_a_found ? S_REL_SCAN : S_DONE;
                end else begin
                    n_state = (r_a_found || r_a_slot_ok) ? S_ACT_ADD : S_DONE;
                end
            end
            S_ACT_ADD: n_state = S_DONE;
            S_REL_SCAN: begin
                if (r_fidx == FCW'(FREE_ENTRIES)) begin
                    n_state = S_REL_DEC;
                end
            end
            S_REL_DEC: n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= cba_pkg::LIMIT_RESET;
            r_cached <= '0;
            r_abytes <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_fcnt   <= '0;
            r_acnt   <= '0;
            r_seq    <= '0;
            r_fvalid <= '0;
            r_avalid <= '0;
            o_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    r_act       <= i_item.action;
                    r_req       <= i_item.request_size;
                    r_taddr     <= i_item.block_address;
                    r_tsize     <= i_item.request_size;
                    r_from_hit  <= 1'b0;
                    r_fidx      <= '0;
                    r_aidx      <= '0;
                    r_best_ok   <= 1'b0;
                    r_a_found   <= 1'b0;
                    r_a_slot_ok <= 1'b0;
                    r_f_slot_ok <= 1'b0;
                    // Unused action answers "not recorded" with zero payload.
                    r_status    <= cba_pkg::STAT_NOT_REC;
                    r_raddr     <= '0;
                    r_rsize     <= '0;
                end
                S_FREE_SCAN: begin
                    if (r_fidx != '0 && scan_cand && scan_better) begin
                        r_best_ok   <= 1'b1;
                        r_best_idx  <= r_fpidx;
                        r_best_size <= free_rd.size;
                        r_best_addr <= free_rd.addr;
                        r_best_age  <= scan_age;
                    end
                    if (r_fidx != FCW'(FREE_ENTRIES)) begin
                        r_fidx  <= r_fidx + 1'b1;
                        r_fpidx <= r_fidx[FIW-1:0];
                    end
                end
                S_ALLOC_DEC: begin
                    if (r_best_ok && fits_twice) begin
                        r_fvalid[r_best_idx] <= 1'b0;
                        r_fcnt     <= r_fcnt - 1'b1;
                        r_cached   <= (r_best_size > r_cached) ? '0 : r_cached - r_best_size;
                        r_hits     <= (r_hits == '1) ? r_hits : r_hits + 1'b1;
                        r_taddr    <= r_best_addr;
                        r_tsize    <= r_best_size;
                        r_from_hit <= 1'b1;
                        r_status   <= cba_pkg::STAT_HIT;
                        r_raddr    <= r_best_addr;
                        r_rsize    <= r_best_size;
                    end else begin
                        r_misses <= (r_misses == '1) ? r_misses : r_misses + 1'b1;
                        r_status <= cba_pkg::STAT_MISS;
                        r_raddr  <= '0;
                        r_rsize  <= r_req;
                    end
                end
                S_ACT_SCAN: begin
                    if (r_aidx != '0) begin
                        if (act_match && !r_a_found) begin
                            r_a_found <= 1'b1;
                            r_a_idx   <= r_apidx;
                            r_a_old   <= act_rd.size;
                        end
                        if (!r_avalid[r_apidx] && !r_a_slot_ok) begin
                            r_a_slot_ok <= 1'b1;
                            r_a_slot    <= r_apidx;
                        end
                    end
                    if (r_aidx != ACW'(ACTIVE_ENTRIES)) begin
                        r_aidx  <= r_aidx + 1'b1;
                        r_apidx <= r_aidx[AIW-1:0];
                    end
                end
                S_ACT_UPD: begin
                    if (r_act == cba_pkg::ACT_RELEASE) begin
                        r_status <= cba_pkg::STAT_FREED;
                        r_raddr  <= r_taddr;
                        r_rsize  <= '0;
                        r_fidx   <= '0;
                        if (r_a_found) begin
                            r_avalid[r_a_idx] <= 1'b0;
                            r_acnt   <= r_acnt - 1'b1;
                            r_abytes <= abytes_sub;
                            r_rsize  <= r_a_old;
                        end
                    end else if (r_a_found) begin
                        // Known address: the size is replaced, old bytes leave the total.
                        r_abytes <= abytes_sub;
                    end else if (r_a_slot_ok) begin
                        r_avalid[r_a_slot] <= 1'b1;
                        r_acnt <= r_acnt + 1'b1;
                    end else if (!r_from_hit) begin
                        r_status <= cba_pkg::STAT_NOT_REC;
                        r_raddr  <= r_taddr;
                        r_rsize  <= r_tsize;
                    end
                end
                S_ACT_ADD: begin
                    r_abytes <= abytes_sum[BB] ? '1 : abytes_sum[BB-1:0];
                    if (!r_from_hit) begin
                        r_status <= cba_pkg::STAT_RECORDED;
                        r_raddr  <= r_taddr;
                        r_rsize  <= r_tsize;
                    end
                end
                S_REL_SCAN: begin
                    if (r_fidx != FCW'(FREE_ENTRIES)) begin
                        if (!r_fvalid[r_fidx[FIW-1:0]] && !r_f_slot_ok) begin
                            r_f_slot_ok <= 1'b1;
                            r_f_slot    <= r_fidx[FIW-1:0];
                        end
                        r_fidx <= r_fidx + 1'b1;
                    end
                end
                S_REL_DEC: begin
                    if (fits_limit) begin
                        r_fvalid[r_f_slot] <= 1'b1;
                        r_fcnt   <= r_fcnt + 1'b1;
                        r_seq    <= r_seq + 1'b1;
                        r_cached <= r_cached + r_a_old;
                        r_status <= cba_pkg::STAT_CACHED;
                    end
                end
                S_DONE: begin
                    o_done <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // The result word is loaded as the sequencer finishes and is held until the next one.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_result.status             <= r_status;
            o_result.result_address     <= r_raddr;
            o_result.result_size        <= r_rsize;
            o_result.hit_count          <= r_hits;
            o_result.miss_count         <= r_misses;
            o_result.cached_block_count <= 7'(r_fcnt);
            o_result.cached_byte_total  <= r_cached;
            o_result.active_block_count <= 9'(r_acnt);
            o_result.active_byte_total  <= r_abytes;
        end
    end

    assign busy = (r_state != S_IDLE);

    `CBA_ASSERT(a_done_ends_busy, $fell(busy) |-> o_done, "busy fell without a result")
    `CBA_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
    `CBA_ASSERT(a_free_cnt, r_fcnt == FCW'($countones(r_fvalid)), "free count out of step")
    `CBA_ASSERT(a_act_cnt, r_acnt == ACW'($countones(r_avalid)), "active count out of step")

endmodule
`default_nettype wire
